[design/bfa_pkg.sv]
// Package for the bitmap frame allocator: sizes, request codes, sequencer states.
// No dependencies.
package bfa_pkg;

  localparam int BLOCK_LIMIT = 32768;
  localparam int BLK_SHIFT   = 12;
  localparam int MAP_WORDS   = BLOCK_LIMIT / 32;
  localparam int WA_W        = $clog2(MAP_WORDS);
  localparam int BIDX_W      = $clog2(BLOCK_LIMIT);
  localparam int CNT_W       = 16;
  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    REQ_ALLOC  = 3'd0,
    REQ_FREE   = 3'd1,
    REQ_INIT   = 3'd2,
    REQ_UNINIT = 3'd3,
    REQ_REINIT = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    WOP_SET  = 2'd0,
    WOP_CLR  = 2'd1,
    WOP_INIT = 2'd2
  } wop_t;

  typedef struct packed {
    logic [31:0] word;
    logic [5:0]  delta;
  } wop_res_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ARD, S_ACHK, S_ABIT, S_RRD, S_RWR, S_DONE
  } state_t;

  localparam logic [1:0] CFG_KIB = 2'd0;
  localparam logic [1:0] CFG_BFB = 2'd1;

endpackage

[design/bfa_wordop.sv]
// Word update unit: applies a block-range mask to one bitmap word and counts changed bits.
// Depends on bfa_pkg.
module bfa_wordop (
  input  bfa_pkg::wop_t             op,
  input  logic [31:0]               word,
  input  logic [bfa_pkg::WA_W-1:0]  widx,
  input  logic [15:0]               lo,
  input  logic [15:0]               hi,
  input  logic [15:0]               pfirst,
  input  logic [15:0]               plast,
  output bfa_pkg::wop_res_t         res
);
  logic [31:0] mask;
  logic [31:0] excl;
  logic [31:0] chg;
  logic [15:0] idx [32];

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      idx[i]  = {1'b0, widx, i[4:0]};
      mask[i] = (idx[i] >= lo) && (idx[i] < hi);
      excl[i] = (idx[i] == 16'd0) || ((idx[i] >= pfirst) && (idx[i] <= plast));
    end
    case (op)
      bfa_pkg::WOP_SET: begin
        chg      = ~word & mask;
        res.word = word | mask;
      end
      bfa_pkg::WOP_INIT: begin
        chg      = word & mask & ~excl;
        res.word = word & ~chg;
      end
      default: begin
        chg      = word & mask;
        res.word = word & ~mask;
      end
    endcase
    res.delta = 6'($countones(chg));
  end
endmodule

[design/bfa_map.sv]
// Usage bitmap store, one word per 32 blocks, registered read.
// Depends on bfa_pkg.
module bfa_map (
  input  logic                      clk,
  input  logic                      we,
  input  logic [bfa_pkg::WA_W-1:0]  waddr,
  input  logic [31:0]               wdata,
  input  logic [bfa_pkg::WA_W-1:0]  raddr,
  output logic [31:0]               rdata
);
  logic [31:0] mem [bfa_pkg::MAP_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[design/bfa_seq.sv]
// Request sequencer: first-fit search, word-by-word region updates, clear sweeps.
// Depends on bfa_pkg, bfa_wordop.
module bfa_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                req_type,
  input  logic [26:0]               address,
  input  logic [15:0]               block_count,
  input  logic [31:0]               byte_length,
  input  logic [17:0]               memory_kib,
  input  logic [14:0]               bitmap_first_block,
  output logic                      map_we,
  output logic [bfa_pkg::WA_W-1:0]  map_waddr,
  output logic [31:0]               map_wdata,
  output logic [bfa_pkg::WA_W-1:0]  map_raddr,
  input  logic [31:0]               map_rdata,
  output logic                      out_valid,
  output logic                      out_ok,
  output logic [26:0]               out_alloc_address,
  output logic [15:0]               out_used_count,
  output logic [15:0]               out_free_blocks
);
  localparam int WA = bfa_pkg::WA_W;

  bfa_pkg::state_t state_r, state_nxt;
  logic [2:0]   req_r, req_nxt;
  logic [WA-1:0] w_r, w_nxt, endw_r, endw_nxt;
  logic [15:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [15:0]  used_r, used_nxt, run_r, run_nxt, cnt_r, cnt_nxt;
  logic [4:0]   bit_r, bit_nxt;
  logic [31:0]  word_r, word_nxt;
  logic         ok_r, ok_nxt, reinit_r, reinit_nxt;
  logic [26:0]  addr_r, addr_nxt;

  logic [15:0]  mb, freeb, pend;
  logic [15:0]  acc_lo, acc_hi;
  logic [20:0]  n_len, n_blk;
  logic [21:0]  first_b, end_b;
  logic [16:0]  base, idx, usum;
  logic [16:0]  start_b;
  logic [15:0]  run_b;
  bfa_pkg::wop_t     wop;
  bfa_pkg::wop_res_t wres;

  assign mb = (memory_kib[17:2] > 16'(bfa_pkg::BLOCK_LIMIT)) ? 16'(bfa_pkg::BLOCK_LIMIT)
                                                            : memory_kib[17:2];
  assign freeb = (mb > used_r) ? mb - used_r : 16'd0;
  assign pend  = {1'b0, bitmap_first_block} + {15'd0, (memory_kib > 18'd131072)};

  always_comb begin
    n_len   = {1'b0, byte_length[31:12]} + {20'd0, |byte_length[11:0]};
    n_blk   = (req_type == bfa_pkg::REQ_FREE) ? {5'd0, block_count} : n_len;
    first_b = {7'd0, address[26:12]};
    end_b   = first_b + {1'b0, n_blk};
    acc_hi  = (end_b > {6'd0, mb}) ? mb : end_b[15:0];
    acc_lo  = (first_b > {6'd0, acc_hi}) ? acc_hi : first_b[15:0];
  end

  always_comb begin
    case (req_r)
      bfa_pkg::REQ_INIT: wop = bfa_pkg::WOP_INIT;
      bfa_pkg::REQ_FREE: wop = bfa_pkg::WOP_CLR;
      default:           wop = bfa_pkg::WOP_SET;
    endcase
  end

  bfa_wordop u_wop (
    .op(wop), .word(map_rdata), .widx(w_r), .lo(lo_r), .hi(hi_r),
    .pfirst({1'b0, bitmap_first_block}), .plast(pend), .res(wres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bfa_pkg::S_CLEAR;
      w_r      <= '0;
      used_r   <= 16'(bfa_pkg::BLOCK_LIMIT);
      reinit_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      w_r      <= w_nxt;
      used_r   <= used_nxt;
      reinit_r <= reinit_nxt;
    end
    req_r  <= req_nxt;
    endw_r <= endw_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    run_r  <= run_nxt;
    cnt_r  <= cnt_nxt;
    bit_r  <= bit_nxt;
    word_r <= word_nxt;
    ok_r   <= ok_nxt;
    addr_r <= addr_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    w_nxt      = w_r;
    endw_nxt   = endw_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    used_nxt   = used_r;
    run_nxt    = run_r;
    cnt_nxt    = cnt_r;
    bit_nxt    = bit_r;
    word_nxt   = word_r;
    ok_nxt     = ok_r;
    addr_nxt   = addr_r;
    reinit_nxt = reinit_r;
    map_we     = 1'b0;
    map_waddr  = w_r;
    map_wdata  = wres.word;
    base       = {2'd0, w_r, 5'd0};
    idx        = base + {12'd0, bit_r};
    start_b    = '0;
    run_b      = '0;
    usum       = '0;
    unique case (state_r)
      bfa_pkg::S_CLEAR: begin
        map_we    = 1'b1;
        map_wdata = '1;
        w_nxt     = w_r + 1'b1;
        if (w_r == WA'(bfa_pkg::MAP_WORDS - 1)) begin
          w_nxt      = '0;
          reinit_nxt = 1'b0;
          state_nxt  = reinit_r ? bfa_pkg::S_DONE : bfa_pkg::S_IDLE;
        end
      end
      bfa_pkg::S_IDLE: begin
        if (start) begin
          req_nxt  = req_type;
          cnt_nxt  = block_count;
          ok_nxt   = 1'b0;
          addr_nxt = '0;
          lo_nxt   = acc_lo;
          hi_nxt   = acc_hi;
          w_nxt    = acc_lo[5 +: WA];
          endw_nxt = 16'(acc_hi - 16'd1) >> 5 > 16'(bfa_pkg::MAP_WORDS - 1) ? '0
                     : WA'(16'(acc_hi - 16'd1) >> 5);
          unique case (req_type) inside
            bfa_pkg::REQ_ALLOC: begin
              w_nxt   = '0;
              run_nxt = '0;
              state_nxt = (block_count != 16'd0 && freeb >= block_count) ? bfa_pkg::S_ARD
                                                                      : bfa_pkg::S_DONE;
            end
            bfa_pkg::REQ_FREE, bfa_pkg::REQ_INIT, bfa_pkg::REQ_UNINIT: begin
              ok_nxt = 1'b1;
              if (req_type == bfa_pkg::REQ_FREE) begin
                used_nxt = (block_count > used_r) ? 16'd0 : used_r - block_count;
              end
              state_nxt = (acc_lo < acc_hi) ? bfa_pkg::S_RRD : bfa_pkg::S_DONE;
            end
            bfa_pkg::REQ_REINIT: begin
              ok_nxt     = 1'b1;
              used_nxt   = mb;
              w_nxt      = '0;
              reinit_nxt = 1'b1;
              state_nxt  = bfa_pkg::S_CLEAR;
            end
            default: state_nxt = bfa_pkg::S_DONE;
          endcase
        end
      end
      bfa_pkg::S_ARD: state_nxt = bfa_pkg::S_ACHK;
      bfa_pkg::S_ACHK: begin
        word_nxt = map_rdata;
        bit_nxt  = '0;
        if (base >= {1'b0, mb}) begin
          state_nxt = bfa_pkg::S_DONE;
        end else if (map_rdata == '1) begin
          run_nxt   = '0;
          w_nxt     = w_r + 1'b1;
          state_nxt = (w_r == WA'(bfa_pkg::MAP_WORDS - 1)) ? bfa_pkg::S_DONE : bfa_pkg::S_ARD;
        end else if (map_rdata == '0 && (base + 17'd32) <= {1'b0, mb}) begin
          run_b = run_r + 16'd32;
          if (run_b >= cnt_r) begin
            start_b = base - {1'b0, run_r};
            lo_nxt  = start_b[15:0];
            hi_nxt  = start_b[15:0] + cnt_r;
          end else begin
            run_nxt   = run_b;
            w_nxt     = w_r + 1'b1;
            state_nxt = (w_r == WA'(bfa_pkg::MAP_WORDS - 1)) ? bfa_pkg::S_DONE
                                                             : bfa_pkg::S_ARD;
          end
        end else begin
          state_nxt = bfa_pkg::S_ABIT;
        end
        if (map_rdata == '0 && (base + 17'd32) <= {1'b0, mb} && run_b >= cnt_r) begin
          ok_nxt    = 1'b1;
          addr_nxt  = {start_b[14:0], 12'd0};
          w_nxt     = start_b[5 +: WA];
          endw_nxt  = WA'(16'(start_b[15:0] + cnt_r - 16'd1) >> 5);
          usum      = {1'b0, used_r} + {1'b0, cnt_r};
          used_nxt  = usum[16] ? bfa_pkg::COUNT_MAX : usum[15:0];
          state_nxt = bfa_pkg::S_RRD;
        end
      end
      bfa_pkg::S_ABIT: begin
        run_b = word_r[bit_r] ? 16'd0 : run_r + 16'd1;
        if (idx >= {1'b0, mb}) begin
          state_nxt = bfa_pkg::S_DONE;
        end else if (run_b == cnt_r) begin
          start_b   = idx + 17'd1 - {1'b0, cnt_r};
          lo_nxt    = start_b[15:0];
          hi_nxt    = idx[15:0] + 16'd1;
          ok_nxt    = 1'b1;
          addr_nxt  = {start_b[14:0], 12'd0};
          w_nxt     = start_b[5 +: WA];
          endw_nxt  = w_r;
          usum      = {1'b0, used_r} + {1'b0, cnt_r};
          used_nxt  = usum[16] ? bfa_pkg::COUNT_MAX : usum[15:0];
          state_nxt = bfa_pkg::S_RRD;
        end else begin
          run_nxt = run_b;
          bit_nxt = bit_r + 5'd1;
          if (bit_r == 5'd31) begin
            w_nxt     = w_r + 1'b1;
            state_nxt = (w_r == WA'(bfa_pkg::MAP_WORDS - 1)) ? bfa_pkg::S_DONE
                                                             : bfa_pkg::S_ARD;
          end
        end
      end
      bfa_pkg::S_RRD: state_nxt = bfa_pkg::S_RWR;
      bfa_pkg::S_RWR: begin
        map_we = 1'b1;
        if (req_r == bfa_pkg::REQ_INIT) begin
          used_nxt = ({10'd0, wres.delta} > used_r) ? 16'd0 : used_r - {10'd0, wres.delta};
        end else if (req_r == bfa_pkg::REQ_UNINIT) begin
          usum     = {1'b0, used_r} + {11'd0, wres.delta};
          used_nxt = usum[16] ? bfa_pkg::COUNT_MAX : usum[15:0];
        end
        w_nxt     = w_r + 1'b1;
        state_nxt = (w_r == endw_r) ? bfa_pkg::S_DONE : bfa_pkg::S_RRD;
      end
      bfa_pkg::S_DONE: begin
        w_nxt     = '0;
        state_nxt = bfa_pkg::S_IDLE;
      end
      default: state_nxt = bfa_pkg::S_IDLE;
    endcase
  end

  assign map_raddr         = w_r;
  assign busy              = (state_r != bfa_pkg::S_IDLE);
  assign out_valid         = (state_r == bfa_pkg::S_DONE);
  assign out_ok            = ok_r;
  assign out_alloc_address = addr_r;
  assign out_used_count    = used_r;
  assign out_free_blocks   = freeb;
endmodule

[design/bitmap_frame_allocator.sv]
// Top level of the bitmap frame allocator: configuration registers, sequencer, bitmap store.
// Depends on bfa_pkg, bfa_seq, bfa_map.
//
//   channel   ports                         transfer
//   request   start/busy, in_*              start high while busy low
//   result    out_valid, out_*              one-cycle strobe, no backpressure
//   config    psel/penable/pwrite/paddr     access phase, pready tied high
//
// Alloc: fully used or fully free bitmap words are judged whole, mixed words are scanned bit by
// bit, then each word of the grant is read and rewritten; the search walks at most 1024 words.
// Free, init and uninit: each word in the range is read and rewritten. Reinit: all 1024 words
// are set to all ones; after reset the store is swept to all ones with busy high.
module bitmap_frame_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [26:0] in_address,
  input  logic [15:0] in_block_count,
  input  logic [31:0] in_byte_length,
  output logic        out_valid,
  output logic        out_ok,
  output logic [26:0] out_alloc_address,
  output logic [15:0] out_used_count,
  output logic [15:0] out_free_blocks,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [17:0] kib_r;
  logic [14:0] bfb_r;
  logic [1:0]  reg_sel;
  logic        map_we;
  logic [bfa_pkg::WA_W-1:0] map_waddr, map_raddr;
  logic [31:0] map_wdata, map_rdata;

  assign pready  = 1'b1;
  assign reg_sel = {1'b0, paddr[2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kib_r <= 18'd131072;
      bfb_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        bfa_pkg::CFG_KIB: kib_r <= pwdata[17:0];
        bfa_pkg::CFG_BFB: bfb_r <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      bfa_pkg::CFG_KIB: prdata = {14'd0, kib_r};
      bfa_pkg::CFG_BFB: prdata = {17'd0, bfb_r};
      default:          prdata = '0;
    endcase
  end

  bfa_seq u_seq (
    .clk, .rst_n, .start, .busy,
    .req_type(in_req_type), .address(in_address), .block_count(in_block_count),
    .byte_length(in_byte_length), .memory_kib(kib_r), .bitmap_first_block(bfb_r),
    .map_we, .map_waddr, .map_wdata, .map_raddr, .map_rdata,
    .out_valid, .out_ok, .out_alloc_address, .out_used_count, .out_free_blocks
  );

  bfa_map u_map (
    .clk, .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );
endmodule

[design/bfa_checker.sv]
// Port-level checker for the bitmap frame allocator, bound to the top level.
// Depends on bitmap_frame_allocator.
module bfa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_ok,
  input logic [26:0] out_alloc_address
);
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("transfer did not raise busy");
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_alloc_address == 27'd0))
    else $error("nonzero address on failure");
  a_free_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy held after result");
endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_ok, .out_alloc_address
);

[test/bitmap_frame_allocator_tb.sv]
// Testbench for bitmap_frame_allocator: directed and random requests checked against
// an in-bench model of the block bitmap and used count. Depends on bfa_pkg and the RTL.
module bitmap_frame_allocator_tb;

  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam int BLK_BYTES = 4096;
  localparam int STALL_LIMIT = 200000;

  typedef struct {
    logic        ok;
    logic [26:0] addr;
    logic [15:0] used;
    logic [15:0] free;
  } alloc_result_t;

  typedef struct {
    int base;
    int len;
  } grant_t;

  logic        clk, rst_n, start, busy;
  logic [2:0]  in_req_type;
  logic [26:0] in_address;
  logic [15:0] in_block_count;
  logic [31:0] in_byte_length;
  logic        out_valid, out_ok;
  logic [26:0] out_alloc_address;
  logic [15:0] out_used_count, out_free_blocks;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  bit          block_used [bfa_pkg::BLOCK_LIMIT];
  int          used_cnt;
  int          mem_kib;
  int          map_first;
  alloc_result_t pending_results [$];
  grant_t      grants [$];
  int          errors = 0;
  int          stall_cycles = 0;
  bit          no_gaps;

  bitmap_frame_allocator dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int managed();
    longint n = longint'(mem_kib) * 1024 / BLK_BYTES;
    return n > bfa_pkg::BLOCK_LIMIT ? bfa_pkg::BLOCK_LIMIT : int'(n);
  endfunction

  function automatic void count_up(int n);
    used_cnt = (used_cnt + n > 65535) ? 65535 : used_cnt + n;
  endfunction

  function automatic void count_down(int n);
    used_cnt = (n > used_cnt) ? 0 : used_cnt - n;
  endfunction

  function automatic void mark_all_used();
    foreach (block_used[i]) block_used[i] = 1'b1;
    used_cnt = 0;
    count_up(managed());
  endfunction

  function automatic void span_blocks(longint a, longint len, output int lo, output int hi);
    longint first = a / BLK_BYTES;
    longint stop = first + (len + BLK_BYTES - 1) / BLK_BYTES;
    longint mb = managed();
    if (stop > mb) stop = mb;
    if (first > stop) first = stop;
    lo = int'(first);
    hi = int'(stop);
  endfunction

  function automatic alloc_result_t allocator_step(logic [2:0] rt, logic [26:0] a,
                                                   logic [15:0] cnt, logic [31:0] len);
    alloc_result_t r;
    int mb = managed();
    int lo, hi, run, freeb;
    longint bytes, pend;
    r.ok = 0;
    r.addr = '0;
    case (rt)
      bfa_pkg::REQ_ALLOC: begin
        freeb = mb > used_cnt ? mb - used_cnt : 0;
        run = 0;
        if (cnt != 0 && freeb >= cnt) begin
          for (int b = 0; b < mb; b++) begin
            run = block_used[b] ? 0 : run + 1;
            if (run == cnt) begin
              for (int k = b + 1 - cnt; k <= b; k++) block_used[k] = 1'b1;
              count_up(cnt);
              r.addr = 27'(longint'(b + 1 - cnt) * BLK_BYTES);
              r.ok = 1;
              break;
            end
          end
        end
      end
      bfa_pkg::REQ_FREE: begin
        span_blocks(a, longint'(cnt) * BLK_BYTES, lo, hi);
        for (int b = lo; b < hi; b++) block_used[b] = 1'b0;
        count_down(cnt);
        r.ok = 1;
      end
      bfa_pkg::REQ_INIT: begin
        bytes = longint'(mem_kib) * 1024;
        pend = map_first + (bytes == 0 ? 0 : (bytes - 1) / (longint'(BLK_BYTES) * 8 * BLK_BYTES));
        span_blocks(a, len, lo, hi);
        for (int b = lo; b < hi; b++) begin
          if (b == 0 || (b >= map_first && b <= pend)) continue;
          if (block_used[b]) begin
            block_used[b] = 1'b0;
            count_down(1);
          end
        end
        r.ok = 1;
      end
      bfa_pkg::REQ_UNINIT: begin
        span_blocks(a, len, lo, hi);
        for (int b = lo; b < hi; b++)
          if (!block_used[b]) begin
            block_used[b] = 1'b1;
            count_up(1);
          end
        r.ok = 1;
      end
      bfa_pkg::REQ_REINIT: begin
        mark_all_used();
        r.ok = 1;
      end
      default: ;
    endcase
    r.used = 16'(used_cnt);
    r.free = 16'(mb > used_cnt ? mb - used_cnt : 0);
    return r;
  endfunction

  task automatic report(string field, longint got, longint want);
    errors++;
    $display("%0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got, want);
  endtask

  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report("unexpected result ok", out_ok, 0);
      end else begin
        e = pending_results.pop_front();
        if (out_ok !== e.ok) report("ok", out_ok, e.ok);
        if (out_alloc_address !== e.addr) report("alloc_address", out_alloc_address, e.addr);
        if (out_used_count !== e.used) report("used_count", out_used_count, e.used);
        if (out_free_blocks !== e.free) report("free_blocks", out_free_blocks, e.free);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || psel) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send(logic [2:0] rt, logic [26:0] a, logic [15:0] cnt, logic [31:0] len);
    alloc_result_t r;
    if (!no_gaps && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_req_type <= rt;
    in_address <= a;
    in_block_count <= cnt;
    in_byte_length <= len;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    r = allocator_step(rt, a, cnt, len);
    if (rt == bfa_pkg::REQ_ALLOC && r.ok)
      grants.push_back('{int'(r.addr) / BLK_BYTES, int'(cnt)});
    if (rt == bfa_pkg::REQ_REINIT) grants.delete();
    pending_results.push_back(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx[0], 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == bfa_pkg::CFG_KIB) mem_kib = value & 32'h3FFFF;
    else if (idx == bfa_pkg::CFG_BFB) map_first = value & 32'h7FFF;
    @(posedge clk);
  endtask

  task automatic test_requests_after_reset();
    send(bfa_pkg::REQ_ALLOC, '0, 16'd0, '0);
    send(bfa_pkg::REQ_ALLOC, '0, 16'd1, '0);
    for (int k = 0; k < 3; k++) send(REQ_UNUSED_LO + 3'(k), 27'h7FFFFFF, 16'hFFFF, '1);
    send(bfa_pkg::REQ_INIT, '0, '0, 32'd0);
    send(bfa_pkg::REQ_INIT, '0, '0, 32'hFFFFFFFF);
    send(bfa_pkg::REQ_ALLOC, '0, 16'd1, '0);
    send(bfa_pkg::REQ_ALLOC, '0, 16'd32768, '0);
    send(bfa_pkg::REQ_ALLOC, '0, 16'd100, '0);
    send(bfa_pkg::REQ_FREE, 27'd4096, 16'd1, '0);
    send(bfa_pkg::REQ_UNINIT, 27'd8192, '0, 32'd5000);
    send(bfa_pkg::REQ_ALLOC, '0, 16'd1, '0);
    send(bfa_pkg::REQ_FREE, 27'h7FFFFFF, 16'hFFFF, '0);
    send(bfa_pkg::REQ_FREE, '0, 16'hFFFF, '0);
    send(bfa_pkg::REQ_UNINIT, 27'h7FFF000, '0, 32'hFFFFFFFF);
    send(bfa_pkg::REQ_REINIT, '0, '0, '0);
  endtask

  task automatic test_register_extremes();
    write_reg(bfa_pkg::CFG_BFB, 32767);
    write_reg(bfa_pkg::CFG_KIB, 262143);
    send(bfa_pkg::REQ_REINIT, '0, '0, '0);
    send(bfa_pkg::REQ_INIT, '0, '0, 32'hFFFFFFFF);
    send(bfa_pkg::REQ_ALLOC, '0, 16'hFFFF, '0);
    send(bfa_pkg::REQ_ALLOC, '0, 16'd3, '0);
    write_reg(bfa_pkg::CFG_KIB, 0);
    send(bfa_pkg::REQ_ALLOC, '0, 16'd1, '0);
    send(bfa_pkg::REQ_FREE, '0, 16'd2, '0);
    send(bfa_pkg::REQ_REINIT, '0, '0, '0);
    write_reg(bfa_pkg::CFG_BFB, 0);
    write_reg(bfa_pkg::CFG_KIB, 4);
    send(bfa_pkg::REQ_REINIT, '0, '0, '0);
    send(bfa_pkg::REQ_INIT, '0, '0, 32'hFFFFFFFF);
    send(bfa_pkg::REQ_ALLOC, '0, 16'd1, '0);
  endtask

  task automatic random_request();
    int mb = managed();
    int pick = $urandom_range(0, 99);
    int blk = $urandom_range(0, mb + 4);
    grant_t g;
    int gi;
    if (pick < 38) begin
      send(bfa_pkg::REQ_ALLOC, 27'($urandom), $urandom_range(0, 9) == 0 ?
           16'($urandom_range(1, mb + 2)) : 16'($urandom_range(1, 8)), $urandom);
    end else if (pick < 60) begin
      if (grants.size() != 0) begin
        gi = $urandom_range(0, grants.size() - 1);
        g = grants[gi];
        grants.delete(gi);
        send(bfa_pkg::REQ_FREE, 27'(g.base * BLK_BYTES), 16'(g.len), $urandom);
      end else begin
        send(bfa_pkg::REQ_FREE, 27'(blk * BLK_BYTES), 16'($urandom_range(1, 4)), $urandom);
      end
    end else if (pick < 74) begin
      send(bfa_pkg::REQ_INIT, 27'(blk * BLK_BYTES + $urandom_range(0, 4095)), '0,
           $urandom_range(0, 16 * BLK_BYTES));
    end else if (pick < 84) begin
      send(bfa_pkg::REQ_UNINIT, 27'(blk * BLK_BYTES + $urandom_range(0, 4095)), '0,
           $urandom_range(0, 8 * BLK_BYTES));
    end else if (pick < 87) begin
      send(bfa_pkg::REQ_REINIT, 27'($urandom), 16'($urandom), $urandom);
    end else if (pick < 90) begin
      send(REQ_UNUSED_LO + 3'($urandom_range(0, 2)), 27'($urandom), 16'($urandom), $urandom);
    end else begin
      send(3'($urandom_range(bfa_pkg::REQ_FREE, bfa_pkg::REQ_UNINIT)), 27'($urandom),
           16'($urandom), $urandom);
    end
  endtask

  task automatic test_random_traffic(int kib, int first, int n, bit quiet);
    write_reg(bfa_pkg::CFG_KIB, kib);
    write_reg(bfa_pkg::CFG_BFB, first);
    no_gaps = quiet;
    send(bfa_pkg::REQ_REINIT, '0, '0, '0);
    send(bfa_pkg::REQ_INIT, '0, '0, 32'hFFFFFFFF);
    for (int k = 0; k < n; k++) begin
      random_request();
      if (k == n / 2) drain();
    end
    no_gaps = 0;
  endtask

  initial begin
    rst_n = 0;
    start = 0;
    in_req_type = bfa_pkg::REQ_ALLOC;
    in_address = '0;
    in_block_count = '0;
    in_byte_length = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    no_gaps = 0;
    mem_kib = 131072;
    map_first = 0;
    mark_all_used();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_requests_after_reset();
    test_register_extremes();
    test_random_traffic($urandom_range(64, 1024), $urandom_range(0, 20), 110, 0);
    test_random_traffic($urandom_range(1024, 8192), $urandom_range(0, 200), 110, 1);
    test_random_traffic(4096, 32767, 110, 0);
    test_random_traffic($urandom_range(4, 64), 0, 110, 0);
    test_random_traffic($urandom_range(8192, 16384), $urandom_range(0, 32767), 110, 0);
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[bitmap_frame_allocator.f]
design/bfa_pkg.sv
design/bfa_wordop.sv
design/bfa_map.sv
design/bfa_seq.sv
design/bitmap_frame_allocator.sv
design/bfa_checker.sv
test/bitmap_frame_allocator_tb.sv
